[hdl/ssg_pkg.sv]
// shared types, widths and constants of the spectral subtraction gain block
`default_nettype none
package ssg_pkg;

  localparam int BIN_W   = 9;
  localparam int POW_W   = 32;
  localparam int SPEC_W  = 24;
  localparam int GAIN_W  = 16;
  localparam int WGT_W   = 16;
  localparam int QUOT_W  = 16;
  localparam int KN_W    = 48;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam int NUM_BINS_DEF = 257;

  // register indexes on the configuration port
  localparam logic [1:0] REG_NOISE_SCALE = 2'd0;
  localparam logic [1:0] REG_NEW_WEIGHT  = 2'd1;
  localparam logic [1:0] REG_KEEP_WEIGHT = 2'd2;

  // register reset values
  localparam logic [WGT_W-1:0] SCALE_RST  = 16'd32768;
  localparam logic [WGT_W-1:0] NEW_W_RST  = 16'd3277;
  localparam logic [WGT_W-1:0] KEEP_W_RST = 16'd62259;

  // gain constants, Q1.15
  localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd32768;
  localparam logic [WGT_W-1:0]  STRONG_K   = 16'd32512;

  typedef struct packed {
    logic [WGT_W-1:0] over_scale;
    logic [WGT_W-1:0] noise_new_weight;
    logic [WGT_W-1:0] noise_keep_weight;
  } cfg_t;

  typedef struct packed {
    logic [BIN_W-1:0]         bin_index;
    logic                     speech_frame;
    logic [POW_W-1:0]         band_power;
    logic signed [SPEC_W-1:0] spec_real;
    logic signed [SPEC_W-1:0] spec_imag;
    logic [POW_W-1:0]         frame_energy;
    logic                     last_bin;
  } in_item_t;

  typedef struct packed {
    logic [BIN_W-1:0]         out_bin_index;
    logic [GAIN_W-1:0]        bin_gain;
    logic signed [SPEC_W-1:0] out_real;
    logic signed [SPEC_W-1:0] out_imag;
    logic [POW_W-1:0]         noise_level;
    logic [POW_W-1:0]         energy_margin;
    logic                     out_last;
  } out_item_t;

  // per-bin data that rides along with the divider
  typedef struct packed {
    logic [BIN_W-1:0]         bin_index;
    logic                     last_bin;
    logic [POW_W-1:0]         noise_level;
    logic [POW_W-1:0]         energy_margin;
    logic signed [SPEC_W-1:0] spec_real;
    logic signed [SPEC_W-1:0] spec_imag;
    logic                     use_div;
    logic [GAIN_W-1:0]        gain_fix;
  } side_t;

  // one divider stage: partial remainder, dividend bits still to come, quotient so far
  typedef struct packed {
    side_t             side;
    logic [POW_W-1:0]  divisor;
    logic [POW_W-1:0]  rem;
    logic [QUOT_W-1:0] low;
    logic [QUOT_W-1:0] quot;
  } div_t;

endpackage
`default_nettype wire

[hdl/ssg_ram.sv]
// generic single-port-write, registered-read RAM
`default_nettype none
module ssg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 257
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

[hdl/ssg_front.sv]
// noise store, noise and margin update, gain rule choice and dividend setup
`default_nettype none
module ssg_front #(
  parameter int NUM_BINS = ssg_pkg::NUM_BINS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ssg_pkg::cfg_t    cfg,
  input  wire logic             up_valid,
  output      logic             up_ready,
  input  wire ssg_pkg::in_item_t up_data,
  output      logic             dn_valid,
  input  wire logic             dn_ready,
  output      ssg_pkg::div_t    dn_data
);

  localparam int AW = $clog2(NUM_BINS);
  localparam int IW = ssg_pkg::BIN_W + 1;
  localparam int PW = ssg_pkg::POW_W;

  typedef struct packed {
    ssg_pkg::side_t          side;
    logic                    wrote;
    logic [PW-1:0]           power;
    logic [ssg_pkg::KN_W-1:0] kn;
  } s2_t;

  logic                 busy_r, busy_nxt;
  logic [AW-1:0]        clr_idx_r, clr_idx_nxt;
  logic                 s1_valid_r;
  ssg_pkg::in_item_t    s1_r;
  logic                 s2_valid_r;
  s2_t                  s2_r, s2_nxt;
  logic [PW-1:0]        margin_r, margin_nxt;
  logic                 s1_en, s2_en;

  logic [IW-1:0]        s1_idx_ext, up_idx_ext;
  logic                 in_range, fwd;
  logic [PW-1:0]        ram_q, noise;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [PW-1:0]        ram_wdata;
  logic [ssg_pkg::KN_W-1:0] keep_prod, new_prod;
  logic [48:0]          acc;
  logic [32:0]          acc_sh;
  logic [PW-1:0]        acc_sat;
  logic [39:0]          m_full;
  logic [32:0]          m_sh;
  logic [PW-1:0]        m_sat;
  logic                 hi_snr, mid, p_zero, use_div, upd_margin;
  logic [37:0]          p40, n41;
  logic [ssg_pkg::WGT_W-1:0]  k;
  logic [ssg_pkg::GAIN_W-1:0] floor_g;
  logic [48:0]          dvd;

  // stage enables: a stage loads when empty or when the next one moves
  assign s2_en    = !s2_valid_r || dn_ready;
  assign s1_en    = !s1_valid_r || s2_en;
  assign up_ready = s1_en && !busy_r;

  // bin index range check and ram address
  assign s1_idx_ext = {1'b0, s1_r.bin_index};
  assign up_idx_ext = {1'b0, up_data.bin_index};
  assign in_range   = s1_idx_ext < IW'(NUM_BINS);

  // latest noise value: forward the write of the item just ahead
  assign fwd   = s2_valid_r && s2_r.wrote && (s2_r.side.bin_index == s1_r.bin_index);
  assign noise = !in_range ? '0 : (fwd ? s2_r.side.noise_level : ram_q);

  // first-order smoothing of the noise power
  always_comb begin
    keep_prod = cfg.noise_keep_weight * noise;
    new_prod  = cfg.noise_new_weight * s1_r.band_power;
    acc     = {1'b0, keep_prod} + {1'b0, new_prod} + 49'd32768;
    acc_sh  = acc[48:16];
    acc_sat = acc_sh[32] ? '1 : acc_sh[PW-1:0];
  end

  // margin average: (127*M + E + 64) / 128
  always_comb begin
    m_full = {1'b0, margin_r, 7'b0} - {8'b0, margin_r} + {8'b0, s1_r.frame_energy} + 40'd64;
    m_sh   = m_full[39:7];
    m_sat  = m_sh[32] ? '1 : m_sh[PW-1:0];
  end

  // speech gain rule selection
  always_comb begin
    p_zero  = (s1_r.band_power == '0);
    hi_snr  = {4'b0, s1_r.band_power} >= {noise, 4'b0};
    p40     = {1'b0, s1_r.band_power, 5'b0} + {3'b0, s1_r.band_power, 3'b0};
    n41     = {1'b0, noise, 5'b0} + {3'b0, noise, 3'b0} + {6'b0, noise};
    mid     = p40 >= n41;
    k       = hi_snr ? ssg_pkg::STRONG_K : cfg.over_scale;
    use_div = s1_r.speech_frame && !p_zero && (hi_snr || mid);
    floor_g = cfg.over_scale[ssg_pkg::WGT_W-1] ? '0
              : ((ssg_pkg::UNITY_GAIN - cfg.over_scale) >> 1);
  end

  assign upd_margin = s1_valid_r && s2_en && !s1_r.speech_frame && s1_r.last_bin;

  // second stage contents
  always_comb begin
    s2_nxt = '0;
    s2_nxt.side.bin_index     = s1_r.bin_index;
    s2_nxt.side.last_bin      = s1_r.last_bin;
    s2_nxt.side.noise_level   = !in_range ? '0 : (s1_r.speech_frame ? noise : acc_sat);
    s2_nxt.side.energy_margin = (!s1_r.speech_frame && s1_r.last_bin) ? m_sat : margin_r;
    s2_nxt.side.spec_real     = s1_r.spec_real;
    s2_nxt.side.spec_imag     = s1_r.spec_imag;
    s2_nxt.side.use_div       = use_div;
    s2_nxt.side.gain_fix      = !s1_r.speech_frame ? ssg_pkg::UNITY_GAIN
                                : ((use_div || p_zero) ? '0 : floor_g);
    s2_nxt.wrote              = !s1_r.speech_frame && in_range;
    s2_nxt.power              = s1_r.band_power;
    s2_nxt.kn                 = k * noise;
  end

  // ram write: clearing sweep after reset, else the noise update
  always_comb begin
    if (busy_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_valid_r && s2_en && !s1_r.speech_frame && in_range;
      ram_waddr = s1_idx_ext[AW-1:0];
      ram_wdata = acc_sat;
    end
  end

  ssg_ram #(
    .WIDTH (PW),
    .DEPTH (NUM_BINS)
  ) u_noise_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (s1_en),
    .raddr (up_idx_ext[AW-1:0]),
    .rdata (ram_q)
  );

  // clearing sweep control
  always_comb begin
    busy_nxt    = busy_r;
    clr_idx_nxt = clr_idx_r;
    if (busy_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == AW'(NUM_BINS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
    margin_nxt = upd_margin ? m_sat : margin_r;
  end

  // dividend: 32768*P - K*N
  assign dvd = {2'b0, s2_r.power, 15'b0} - {1'b0, s2_r.kn};

  always_comb begin
    dn_valid              = s2_valid_r;
    dn_data.side          = s2_r.side;
    dn_data.side.use_div  = s2_r.side.use_div && !dvd[48];
    dn_data.divisor       = s2_r.power;
    dn_data.rem           = {1'b0, dvd[46:16]};
    dn_data.low           = dvd[15:0];
    dn_data.quot          = '0;
  end

  // control and stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_idx_r  <= '0;
      margin_r   <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      clr_idx_r <= clr_idx_nxt;
      margin_r  <= margin_nxt;
      if (s1_en) begin
        s1_valid_r <= up_valid && up_ready;
        s1_r       <= up_data;
      end
      if (s2_en) begin
        s2_valid_r <= s1_valid_r;
        s2_r       <= s2_nxt;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/ssg_div.sv]
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module ssg_div (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          up_valid,
  output      logic          up_ready,
  input  wire ssg_pkg::div_t up_data,
  output      logic          dn_valid,
  input  wire logic          dn_ready,
  output      ssg_pkg::div_t dn_data
);

  localparam int NST = ssg_pkg::QUOT_W;
  localparam int PW  = ssg_pkg::POW_W;

  logic          v_r  [NST];
  ssg_pkg::div_t st_r [NST];
  ssg_pkg::div_t st_nxt [NST];
  logic          en   [NST];
  logic          vin  [NST];

  // one quotient bit: shift in the next dividend bit and try to subtract
  function automatic ssg_pkg::div_t div_step(input ssg_pkg::div_t d);
    ssg_pkg::div_t r;
    logic [PW:0]   t;
    logic [PW:0]   diff;
    r    = d;
    t    = {d.rem, d.low[ssg_pkg::QUOT_W-1]};
    diff = t - {1'b0, d.divisor};
    if (t >= {1'b0, d.divisor}) begin
      r.rem  = diff[PW-1:0];
      r.quot = {d.quot[ssg_pkg::QUOT_W-2:0], 1'b1};
    end else begin
      r.rem  = t[PW-1:0];
      r.quot = {d.quot[ssg_pkg::QUOT_W-2:0], 1'b0};
    end
    r.low = {d.low[ssg_pkg::QUOT_W-2:0], 1'b0};
    return r;
  endfunction

  genvar i;
  generate
    for (i = 0; i < NST; i++) begin : g_stage
      // stage input and enable
      if (i == 0) begin : g_first
        assign st_nxt[i] = div_step(up_data);
        assign vin[i]    = up_valid;
      end else begin : g_next
        assign st_nxt[i] = div_step(st_r[i-1]);
        assign vin[i]    = v_r[i-1];
      end
      if (i == NST - 1) begin : g_last
        assign en[i] = !v_r[i] || dn_ready;
      end else begin : g_mid
        assign en[i] = !v_r[i] || en[i+1];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i] <= 1'b0;
        end else if (en[i]) begin
          v_r[i]  <= vin[i];
          st_r[i] <= st_nxt[i];
        end
      end
    end
  endgenerate

  assign up_ready = en[0];
  assign dn_valid = v_r[NST-1];
  assign dn_data  = st_r[NST-1];

endmodule
`default_nettype wire

[hdl/ssg_apply.sv]
// final gain choice, spectrum scaling with rounding, output register
`default_nettype none
module ssg_apply (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output      logic              up_ready,
  input  wire ssg_pkg::div_t     up_data,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      ssg_pkg::out_item_t out_data
);

  logic                        out_valid_r;
  ssg_pkg::out_item_t          out_r, out_nxt;
  logic                        en;
  logic [ssg_pkg::GAIN_W-1:0]  g;
  logic signed [40:0]          sum_re, sum_im;

  assign en       = !out_valid_r || out_ready;
  assign up_ready = en;

  // gain: quotient or fixed value; the scaled spectrum is rounded to nearest
  always_comb begin
    g       = up_data.side.use_div ? up_data.quot : up_data.side.gain_fix;
    sum_re  = $signed(up_data.side.spec_real) * $signed({1'b0, g}) + 41'sd16384;
    sum_im  = $signed(up_data.side.spec_imag) * $signed({1'b0, g}) + 41'sd16384;
    out_nxt.out_bin_index = up_data.side.bin_index;
    out_nxt.bin_gain      = g;
    out_nxt.out_real      = sum_re[38:15];
    out_nxt.out_imag      = sum_im[38:15];
    out_nxt.noise_level   = up_data.side.noise_level;
    out_nxt.energy_margin = up_data.side.energy_margin;
    out_nxt.out_last      = up_data.side.last_bin;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= up_valid;
      out_r       <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

[hdl/spectral_subtraction_gain.sv]
// Per-bin spectral subtraction gain: noise tracking in silence, gain in speech.
// Input channel in_valid/in_ready/in_data carries one frequency bin per request;
// the output channel out_valid/out_ready/out_data returns one result per bin,
// in order. An APB-style port sets the oversubtraction scale (0x0), noise_new_weight
// (0x4) and noise_keep_weight (0x8); write it only while no bins are in flight.
// A request passes two front stages (noise read, update and rule choice, then
// dividend), 16 divider stages producing one quotient bit each, and the output
// register. Throughput is one bin per cycle while the receiver does not stall;
// the divider is a 16-stage restoring divider.
// After reset the noise store is swept to zero, one entry a cycle, over all
// NUM_BINS entries; in_ready stays low meanwhile, register writes still work.
// When the receiver stalls, each stage holds its request and empty stages
// ahead of it keep filling, so new bins are taken until the pipeline is full.
// Nothing is dropped or repeated.
`default_nettype none
module spectral_subtraction_gain #(
  parameter int NUM_BINS = ssg_pkg::NUM_BINS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire ssg_pkg::in_item_t             in_data,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      ssg_pkg::out_item_t            out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ssg_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [ssg_pkg::DATA_W-1:0]    pwdata,
  output      logic [ssg_pkg::DATA_W-1:0]    prdata,
  output      logic                          pready
);

  ssg_pkg::cfg_t  cfg_r, cfg_nxt;
  logic           cfg_wr;
  logic [1:0]     reg_idx;
  logic           f_valid, f_ready, d_valid, d_ready;
  ssg_pkg::div_t  f_data, d_data;

  // register write and read decode
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        ssg_pkg::REG_NOISE_SCALE: cfg_nxt.over_scale        = pwdata[ssg_pkg::WGT_W-1:0];
        ssg_pkg::REG_NEW_WEIGHT:  cfg_nxt.noise_new_weight  = pwdata[ssg_pkg::WGT_W-1:0];
        ssg_pkg::REG_KEEP_WEIGHT: cfg_nxt.noise_keep_weight = pwdata[ssg_pkg::WGT_W-1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ssg_pkg::REG_NOISE_SCALE: prdata = {16'b0, cfg_r.over_scale};
      ssg_pkg::REG_NEW_WEIGHT:  prdata = {16'b0, cfg_r.noise_new_weight};
      ssg_pkg::REG_KEEP_WEIGHT: prdata = {16'b0, cfg_r.noise_keep_weight};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.over_scale        <= ssg_pkg::SCALE_RST;
      cfg_r.noise_new_weight  <= ssg_pkg::NEW_W_RST;
      cfg_r.noise_keep_weight <= ssg_pkg::KEEP_W_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // noise store, updates and dividend setup
  ssg_front #(
    .NUM_BINS (NUM_BINS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .dn_data  (f_data)
  );

  // gain quotient
  ssg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_data  (f_data),
    .dn_valid (d_valid),
    .dn_ready (d_ready),
    .dn_data  (d_data)
  );

  // spectrum scaling and output register
  ssg_apply u_apply (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (d_valid),
    .up_ready  (d_ready),
    .up_data   (d_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
